FILE: rtl/core/qpt_pkg.sv
// Package for the quaternion point transform: operation and status codes,
// register indexes, datapath widths and reset values. No dependencies.
package qpt_pkg;

	typedef enum logic [1:0] {
		OP_FWD_LOC = 2'd0,
		OP_FWD_DIR = 2'd1,
		OP_INV_LOC = 2'd2,
		OP_INV_DIR = 2'd3
	} qpt_op_t;

	typedef enum logic [2:0] {
		REG_SCALE    = 3'd0,
		REG_ROTATION = 3'd1,
		REG_OFFSET_X = 3'd2,
		REG_OFFSET_Y = 3'd3,
		REG_OFFSET_Z = 3'd4
	} qpt_reg_t;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_SAT = 2'd1;
	localparam logic [1:0] ST_DZ  = 2'd2;

	localparam logic [47:0] SCALE_RESET = 48'h0100_0100_0100;
	localparam logic [63:0] ROT_RESET   = 64'h4000_0000_0000_0000;

	localparam int PW  = 41;  // scaled or offset vector
	localparam int MW1 = 58;  // first cross-product terms
	localparam int CW  = 60;  // first cross product, doubled
	localparam int TW  = 46;  // rounded t vector
	localparam int MW2 = 63;  // second cross-product terms
	localparam int WW  = 62;  // w * t
	localparam int SW  = 66;  // rotation sum
	localparam int VW  = 53;  // rotated vector plus offset
	localparam int DW  = 62;  // rounded dividend magnitude
	localparam int QW  = 32;  // quotient bits
	localparam int RW  = 16;  // divisor and remainder
	localparam int DIV_STAGES = 8;
	localparam int BITS_PER_STAGE = QW / DIV_STAGES;

	localparam logic [31:0] SAT_POS = 32'h7fff_ffff;
	localparam logic [31:0] SAT_NEG = 32'h8000_0000;

	typedef struct packed {
		logic [RW-1:0] rem;
		logic [QW-1:0] quo;
		logic [RW-1:0] dvs;
		logic          big;
		logic          neg;
		logic          dz;
		logic          npos;
		logic          nneg;
		logic [31:0]   res;
		logic          ovf;
	} qpt_div_t;

	// Rotation axis component k, negated for the conjugate.
	function automatic logic signed [16:0] qpt_axis(logic [63:0] rot, logic conj,
			logic [1:0] k);
		logic signed [16:0] a;
		a = 17'(signed'(rot[47 - 16*k -: 16]));
		return conj ? -a : a;
	endfunction

endpackage

FILE: rtl/core/quaternion_point_transform.sv
// Quaternion point transform: scale, rotate and translate of Q16.16 vectors.
// Uses qpt_pkg for codes, widths and the divider stage record.
//
// Fifteen-stage pipeline, one transaction per cycle while the output is not held.
// Stage 1 scales or removes the offset, stages 2-5 rotate with two registered
// cross products, stage 6 adds the forward offset, saturates and sets up the
// divide for inverse location, stages 7-14 form the 32-bit quotient four bits
// each, stage 15 applies sign and status. The whole pipeline holds while a
// result waits under out_stall. Configuration is read live and must only
// change while the pipeline is empty.
module quaternion_point_transform
	import qpt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [5:0]         paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         operation,
	input  logic signed [31:0] in_x,
	input  logic signed [31:0] in_y,
	input  logic signed [31:0] in_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic [1:0]         status
);

	logic [47:0]        scale_q;
	logic [63:0]        rot_q;
	logic signed [31:0] off_q [3];
	logic               adv;
	qpt_reg_t           widx;

	logic [15:1]        vld_s;
	qpt_op_t            op_s [1:15];

	logic signed [PW-1:0]  p_s1 [3];
	logic signed [PW-1:0]  p_s2 [3];
	logic signed [PW-1:0]  p_s3 [3];
	logic signed [PW-1:0]  p_s4 [3];
	logic signed [MW1-1:0] ma_s2 [3];
	logic signed [MW1-1:0] mb_s2 [3];
	logic signed [TW-1:0]  t_s3 [3];
	logic signed [MW2-1:0] ma_s4 [3];
	logic signed [MW2-1:0] mb_s4 [3];
	logic signed [WW-1:0]  wt_s4 [3];
	logic signed [VW-1:0]  v_s5 [3];
	qpt_div_t              div_s [6:14][3];
	logic signed [31:0]    res_s15 [3];
	logic [1:0]            st_s15;

	assign adv      = !(vld_s[15] && out_stall);
	assign in_stall = !adv;
	assign pready   = 1'b1;
	assign widx     = qpt_reg_t'(paddr[5:3]);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
			rot_q   <= ROT_RESET;
			off_q   <= '{default: '0};
		end else if (psel && penable && pwrite && pready) begin
			unique case (widx)
				REG_SCALE:    scale_q  <= pwdata[47:0];
				REG_ROTATION: rot_q    <= pwdata;
				REG_OFFSET_X: off_q[0] <= pwdata[31:0];
				REG_OFFSET_Y: off_q[1] <= pwdata[31:0];
				REG_OFFSET_Z: off_q[2] <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (widx)
			REG_SCALE:    prdata = {16'd0, scale_q};
			REG_ROTATION: prdata = rot_q;
			REG_OFFSET_X: prdata = {32'd0, off_q[0]};
			REG_OFFSET_Y: prdata = {32'd0, off_q[1]};
			REG_OFFSET_Z: prdata = {32'd0, off_q[2]};
			default:      prdata = '0;
		endcase
	end

	// valid and operation chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[14:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s[1] <= qpt_op_t'(operation);
			for (int k = 2; k <= 15; k++)
				op_s[k] <= op_s[k-1];
		end
	end

	// stage 1: scale or remove offset
	always_ff @(posedge clk) begin
		logic signed [31:0] vin [3];
		logic signed [47:0] prod;
		logic signed [15:0] sc;
		vin = '{in_x, in_y, in_z};
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				sc   = signed'(scale_q[47 - 16*i -: 16]);
				prod = 48'(vin[i]) * 48'(sc);
				case (qpt_op_t'(operation))
					OP_FWD_LOC: p_s1[i] <= PW'((prod + 48'sd128) >>> 8);
					OP_INV_LOC: p_s1[i] <= PW'(vin[i]) - PW'(off_q[i]);
					default:    p_s1[i] <= PW'(vin[i]);
				endcase
			end
		end
	end

	// stage 2: u x p terms
	always_ff @(posedge clk) begin
		logic signed [16:0] u [3];
		for (int i = 0; i < 3; i++)
			u[i] = qpt_axis(rot_q, op_s[1][1], 2'(i));
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				ma_s2[i] <= MW1'(u[(i+1)%3]) * MW1'(p_s1[(i+2)%3]);
				mb_s2[i] <= MW1'(u[(i+2)%3]) * MW1'(p_s1[(i+1)%3]);
				p_s2[i]  <= p_s1[i];
			end
		end
	end

	// stage 3: t = round(2 * (u x p))
	always_ff @(posedge clk) begin
		logic signed [CW-1:0] c;
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				c = (CW'(ma_s2[i]) - CW'(mb_s2[i])) <<< 1;
				t_s3[i] <= TW'((c + CW'(8192)) >>> 14);
				p_s3[i] <= p_s2[i];
			end
		end
	end

	// stage 4: w * t and u x t terms
	always_ff @(posedge clk) begin
		logic signed [16:0] u [3];
		logic signed [15:0] w;
		for (int i = 0; i < 3; i++)
			u[i] = qpt_axis(rot_q, op_s[3][1], 2'(i));
		w = signed'(rot_q[63:48]);
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				ma_s4[i] <= MW2'(u[(i+1)%3]) * MW2'(t_s3[(i+2)%3]);
				mb_s4[i] <= MW2'(u[(i+2)%3]) * MW2'(t_s3[(i+1)%3]);
				wt_s4[i] <= WW'(w) * WW'(t_s3[i]);
				p_s4[i]  <= p_s3[i];
			end
		end
	end

	// stage 5: combine and round
	always_ff @(posedge clk) begin
		logic signed [SW-1:0] sum;
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				sum = (SW'(p_s4[i]) <<< 14) + SW'(wt_s4[i]) + SW'(ma_s4[i])
					- SW'(mb_s4[i]) + SW'(8192);
				v_s5[i] <= VW'(sum >>> 14);
			end
		end
	end

	// stage 6: add offset, saturate, set up divide
	always_ff @(posedge clk) begin
		logic signed [VW-1:0] v;
		logic signed [15:0]   sc;
		logic [DW-1:0]        an;
		logic [DW-1:0]        d;
		logic [RW-1:0]        as;
		qpt_div_t             e;
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				v  = v_s5[i];
				if (op_s[5] == OP_FWD_LOC)
					v = v + VW'(off_q[i]);
				sc = signed'(scale_q[47 - 16*i -: 16]);
				as = sc[15] ? RW'(-17'(sc)) : RW'(sc);
				an = v[VW-1] ? DW'(-(DW'(v))) << 8 : DW'(v) << 8;
				d  = an + DW'(as >> 1);
				e.dvs  = as;
				e.big  = d[DW-1:QW] >= (DW-QW)'(as);
				e.rem  = d[QW+RW-1:QW];
				e.quo  = d[QW-1:0];
				e.neg  = v[VW-1] ^ sc[15];
				e.dz   = (as == '0);
				e.nneg = v[VW-1];
				e.npos = !v[VW-1] && (v != '0);
				if (v[VW-1:31] == '0 || v[VW-1:31] == '1) begin
					e.res = v[31:0];
					e.ovf = 1'b0;
				end else begin
					e.res = v[VW-1] ? SAT_NEG : SAT_POS;
					e.ovf = 1'b1;
				end
				div_s[6][i] <= e;
			end
		end
	end

	// stages 7-14: restoring divide, four quotient bits per stage
	always_ff @(posedge clk) begin
		qpt_div_t        e;
		logic [RW:0]     r;
		if (adv) begin
			for (int k = 7; k <= 14; k++) begin
				for (int i = 0; i < 3; i++) begin
					e = div_s[k-1][i];
					for (int b = 0; b < BITS_PER_STAGE; b++) begin
						r = {e.rem, e.quo[QW-1]};
						if (r >= {1'b0, e.dvs}) begin
							e.rem = RW'(r - {1'b0, e.dvs});
							e.quo = {e.quo[QW-2:0], 1'b1};
						end else begin
							e.rem = r[RW-1:0];
							e.quo = {e.quo[QW-2:0], 1'b0};
						end
					end
					div_s[k][i] <= e;
				end
			end
		end
	end

	// stage 15: sign, saturation and status
	always_ff @(posedge clk) begin
		qpt_div_t e;
		logic     anyo;
		logic     anyz;
		anyo = 1'b0;
		anyz = 1'b0;
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				e = div_s[14][i];
				if (op_s[14] != OP_INV_LOC) begin
					res_s15[i] <= e.res;
					anyo = anyo | e.ovf;
				end else if (e.dz) begin
					anyz = 1'b1;
					res_s15[i] <= e.npos ? SAT_POS : (e.nneg ? SAT_NEG : 32'd0);
				end else if (e.big) begin
					anyo = 1'b1;
					res_s15[i] <= e.neg ? SAT_NEG : SAT_POS;
				end else if (!e.neg) begin
					anyo = anyo | e.quo[31];
					res_s15[i] <= e.quo[31] ? SAT_POS : e.quo;
				end else if (e.quo > SAT_NEG) begin
					anyo = 1'b1;
					res_s15[i] <= SAT_NEG;
				end else begin
					res_s15[i] <= -e.quo;
				end
			end
			st_s15 <= anyz ? ST_DZ : (anyo ? ST_SAT : ST_OK);
		end
	end

	assign out_valid = vld_s[15];
	assign out_x     = res_s15[0];
	assign out_y     = res_s15[1];
	assign out_z     = res_s15[2];
	assign status    = st_s15;

	a_stall_rule: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall does not follow output hold");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_SAT || status == ST_DZ))
		else $error("status code out of range");

	a_dz_op: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_DZ) |-> (op_s[15] == OP_INV_LOC))
		else $error("divide-by-zero status on a non-divide transaction");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> $stable(vld_s))
		else $error("pipeline advanced while output held");

endmodule
